// ===== rtl/core/aff3d_pkg.sv =====
// Shared types, field codes and fixed-point constants for the 3D affine transform composer.
// No dependencies; every other file of the block imports this package.
package aff3d_pkg;

    // Matrix coefficient width; entries carry FRAC_BITS fraction bits.
    localparam int COEFF_WIDTH = 32;
    localparam int Q_WIDTH     = 32;
    localparam int FRAC_BITS   = 16;
    localparam int OP_WIDTH    = Q_WIDTH + 1;

    // Width of a coefficient times a command operand, and of the accumulation.
    localparam int PROD_W = COEFF_WIDTH + OP_WIDTH;
    localparam int SUM_W  = COEFF_WIDTH + OP_WIDTH + 3;

    typedef logic [2:0]                     kind_t;
    typedef logic [1:0]                     axis_t;
    typedef logic [1:0]                     row_idx_t;
    typedef logic signed [Q_WIDTH-1:0]      q_t;
    typedef logic signed [OP_WIDTH-1:0]     op_t;
    typedef logic signed [COEFF_WIDTH-1:0]  coeff_t;
    typedef logic signed [SUM_W-1:0]        wide_t;
    typedef coeff_t                         row_t [4];

    // Command codes.
    localparam kind_t KIND_IDENTITY  = 3'd0;
    localparam kind_t KIND_TRANSLATE = 3'd1;
    localparam kind_t KIND_SCALE     = 3'd2;
    localparam kind_t KIND_ROTATE    = 3'd3;
    localparam kind_t KIND_REFLECT   = 3'd4;
    localparam kind_t KIND_SHEAR     = 3'd5;
    localparam kind_t KIND_POINT     = 3'd6;

    // Axis codes; AXIS_NONE makes rotate, reflect and shear a no-op.
    localparam axis_t AXIS_X    = 2'd0;
    localparam axis_t AXIS_Y    = 2'd1;
    localparam axis_t AXIS_Z    = 2'd2;
    localparam axis_t AXIS_NONE = 2'd3;

    localparam row_idx_t ROW_X = 2'd0;
    localparam row_idx_t ROW_Y = 2'd1;
    localparam row_idx_t ROW_Z = 2'd2;

    // How a row's old value enters its new value, before the product terms.
    localparam logic [1:0] BASE_ZERO = 2'd0;
    localparam logic [1:0] BASE_KEEP = 2'd1;
    localparam logic [1:0] BASE_NEG  = 2'd2;

    localparam coeff_t ONE_Q = coeff_t'(1 <<< FRAC_BITS);

    localparam wide_t ROUND_HALF = wide_t'(1) <<< (FRAC_BITS - 1);
    localparam wide_t COEFF_MAX_W =
        {{(SUM_W - COEFF_WIDTH + 1){1'b0}}, {(COEFF_WIDTH - 1){1'b1}}};
    localparam wide_t COEFF_MIN_W =
        {{(SUM_W - COEFF_WIDTH + 1){1'b1}}, {(COEFF_WIDTH - 1){1'b0}}};
    localparam wide_t Q_MAX_W =
        {{(SUM_W - Q_WIDTH + 1){1'b0}}, {(Q_WIDTH - 1){1'b1}}};
    localparam wide_t Q_MIN_W =
        {{(SUM_W - Q_WIDTH + 1){1'b1}}, {(Q_WIDTH - 1){1'b0}}};

    // New row = sat(base + round(p * u_row + q * v_row) + t), with t only in the translation column.
    typedef struct packed {
        logic [1:0] base_mode;
        op_t        p;
        op_t        q;
        q_t         t;
    } row_ctrl_t;

endpackage

// ===== rtl/core/aff3d_if.sv =====
// Valid/ready channel interfaces: the command channel and the transformed point channel.
// Depends on aff3d_pkg for the field types.
interface aff3d_cmd_if;
    import aff3d_pkg::*;

    logic  valid;
    logic  ready;
    kind_t kind;
    axis_t axis;
    q_t    operand_a;
    q_t    operand_b;
    q_t    operand_c;

    modport source (output valid, kind, axis, operand_a, operand_b, operand_c, input ready);
    modport sink   (input valid, kind, axis, operand_a, operand_b, operand_c, output ready);
endinterface

interface aff3d_pnt_if;
    import aff3d_pkg::*;

    logic valid;
    logic ready;
    q_t   out_x;
    q_t   out_y;
    q_t   out_z;
    logic saturated;

    modport source (output valid, out_x, out_y, out_z, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

// ===== rtl/core/aff3d_row_unit.sv =====
// One row of the matrix update: two products per column, rounding and saturation.
// Depends on aff3d_pkg.
module aff3d_row_unit (
    input  aff3d_pkg::row_ctrl_t ctrl,
    input  aff3d_pkg::row_t      self_row,
    input  aff3d_pkg::row_t      u_row,
    input  aff3d_pkg::row_t      v_row,
    output aff3d_pkg::row_t      new_row
);
    import aff3d_pkg::*;

    logic signed [PROD_W-1:0] prod_u [4];
    logic signed [PROD_W-1:0] prod_v [4];
    wide_t                    rnd    [4];
    wide_t                    base   [4];
    wide_t                    total  [4];

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            prod_u[j] = $signed(ctrl.p) * u_row[j];
            prod_v[j] = $signed(ctrl.q) * v_row[j];
            rnd[j]    = (wide_t'(prod_u[j]) + wide_t'(prod_v[j]) + ROUND_HALF) >>> FRAC_BITS;

            case (ctrl.base_mode)
                BASE_KEEP: base[j] = wide_t'(self_row[j]);
                BASE_NEG:  base[j] = -wide_t'(self_row[j]);
                default:   base[j] = '0;
            endcase

            // The translation column also takes the translate offset, added after rounding.
            total[j] = base[j] + rnd[j] + ((j == 3) ? wide_t'($signed(ctrl.t)) : '0);

            if (total[j] > COEFF_MAX_W)
            begin
                new_row[j] = COEFF_MAX_W[COEFF_WIDTH-1:0];
            end
            else if (total[j] < COEFF_MIN_W)
            begin
                new_row[j] = COEFF_MIN_W[COEFF_WIDTH-1:0];
            end
            else
            begin
                new_row[j] = total[j][COEFF_WIDTH-1:0];
            end
        end
    end

endmodule

// ===== rtl/core/aff3d_point_unit.sv =====
// One output coordinate of a point transform: row dot point, round, add translation, saturate.
// Depends on aff3d_pkg.
module aff3d_point_unit (
    input  aff3d_pkg::row_t m_row,
    input  aff3d_pkg::q_t   px,
    input  aff3d_pkg::q_t   py,
    input  aff3d_pkg::q_t   pz,
    output aff3d_pkg::q_t   coord,
    output logic            clipped
);
    import aff3d_pkg::*;

    localparam int PP_W = COEFF_WIDTH + Q_WIDTH;

    logic signed [PP_W-1:0] prod_x;
    logic signed [PP_W-1:0] prod_y;
    logic signed [PP_W-1:0] prod_z;
    wide_t                  rnd;
    wide_t                  total;

    assign prod_x = m_row[0] * px;
    assign prod_y = m_row[1] * py;
    assign prod_z = m_row[2] * pz;

    always_comb
    begin
        rnd   = (wide_t'(prod_x) + wide_t'(prod_y) + wide_t'(prod_z) + ROUND_HALF) >>> FRAC_BITS;
        total = rnd + wide_t'(m_row[3]);

        if (total > Q_MAX_W)
        begin
            coord   = Q_MAX_W[Q_WIDTH-1:0];
            clipped = 1'b1;
        end
        else if (total < Q_MIN_W)
        begin
            coord   = Q_MIN_W[Q_WIDTH-1:0];
            clipped = 1'b1;
        end
        else
        begin
            coord   = total[Q_WIDTH-1:0];
            clipped = 1'b0;
        end
    end

endmodule

// ===== rtl/core/affine_transform_3d_composer_unit.sv =====
// Top level of the 3D affine transform composer: command register, matrix state, output register.
// Depends on aff3d_pkg, aff3d_if, aff3d_row_unit and aff3d_point_unit.
//
// The block holds a 3x4 affine matrix (last row implied 0 0 0 1) in Q16.16 and takes one
// command word per clock cycle unless a point word is held behind a stalled output. Identity
// reloads the unit matrix; translate, scale, rotate, reflect and shear words pre-multiply it.
// The new matrix is written at the end of the cycle after the word is accepted, so the very
// next word already sees it. A point word passes the command register and the output register
// to the point channel, saturated to 32 bits with a flag. The logic between the command register
// and the matrix and output register works in one pass: 24 coefficient-by-operand multipliers
// update the matrix and 9 more transform the point. While a point word waits at the output,
// further words are still taken; only a second point in the command register stalls the input.
module affine_transform_3d_composer_unit (
    input  logic       clk,
    input  logic       rst_n,
    aff3d_cmd_if.sink   cmd,
    aff3d_pnt_if.source point
);
    import aff3d_pkg::*;

    // Command register.
    logic  in_valid_reg;
    logic  in_valid_next;
    kind_t kind_reg;
    axis_t axis_reg;
    q_t    a_reg;
    q_t    b_reg;
    q_t    c_reg;

    // Matrix state.
    row_t mat_reg  [3];
    row_t mat_next [3];

    // Output register.
    logic out_valid_reg;
    logic out_valid_next;
    q_t   out_x_reg;
    q_t   out_y_reg;
    q_t   out_z_reg;
    logic sat_reg;

    logic      stall;
    logic      advance;
    logic      take_cmd;
    logic      is_point;
    row_idx_t  lo_idx;
    row_idx_t  hi_idx;
    row_idx_t  refl_idx;
    op_t       sine_eff;
    row_ctrl_t ctrl      [3];
    row_t      u_sel     [3];
    row_t      row_new   [3];
    q_t        coord     [3];
    logic      clip      [3];

    assign is_point   = (kind_reg == KIND_POINT);
    assign stall      = in_valid_reg && is_point && out_valid_reg && !point.ready;
    assign advance    = in_valid_reg && !stall;
    assign cmd.ready  = !stall;
    assign take_cmd   = cmd.valid && cmd.ready;

    assign point.valid     = out_valid_reg;
    assign point.out_x     = out_x_reg;
    assign point.out_y     = out_y_reg;
    assign point.out_z     = out_z_reg;
    assign point.saturated = sat_reg;

    // The two rows a rotation mixes, which are also the two rows a shear reads.
    assign lo_idx   = (axis_reg == AXIS_X) ? ROW_Y : ROW_X;
    assign hi_idx   = (axis_reg == AXIS_Z) ? ROW_Y : ROW_Z;
    // Reflection codes name the negated axis as z, x, y.
    assign refl_idx = (axis_reg == AXIS_X) ? ROW_Z : ((axis_reg == AXIS_Y) ? ROW_X : ROW_Y);
    // Rotation about y has the sine terms mirrored compared with x and z.
    assign sine_eff = (axis_reg == AXIS_Y) ? -op_t'(b_reg) : op_t'(b_reg);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ctrl[i]  = '{base_mode: BASE_KEEP, p: '0, q: '0, t: '0};
            u_sel[i] = mat_reg[lo_idx];
        end

        case (kind_reg)
            KIND_TRANSLATE:
            begin
                ctrl[0].t = a_reg;
                ctrl[1].t = b_reg;
                ctrl[2].t = c_reg;
            end
            KIND_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ctrl[i].base_mode = BASE_ZERO;
                    u_sel[i]          = mat_reg[i];
                end
                ctrl[0].p = op_t'(a_reg);
                ctrl[1].p = op_t'(b_reg);
                ctrl[2].p = op_t'(c_reg);
            end
            KIND_ROTATE:
            begin
                if (axis_reg != AXIS_NONE)
                begin
                    ctrl[lo_idx].base_mode = BASE_ZERO;
                    ctrl[lo_idx].p         = op_t'(a_reg);
                    ctrl[lo_idx].q         = -sine_eff;
                    ctrl[hi_idx].base_mode = BASE_ZERO;
                    ctrl[hi_idx].p         = sine_eff;
                    ctrl[hi_idx].q         = op_t'(a_reg);
                end
            end
            KIND_REFLECT:
            begin
                if (axis_reg != AXIS_NONE)
                begin
                    ctrl[refl_idx].base_mode = BASE_NEG;
                end
            end
            KIND_SHEAR:
            begin
                if (axis_reg != AXIS_NONE)
                begin
                    ctrl[axis_reg].p = op_t'(a_reg);
                    ctrl[axis_reg].q = op_t'(b_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_rows
        aff3d_row_unit u_row (
            .ctrl     (ctrl[r]),
            .self_row (mat_reg[r]),
            .u_row    (u_sel[r]),
            .v_row    (mat_reg[hi_idx]),
            .new_row  (row_new[r])
        );

        aff3d_point_unit u_point (
            .m_row   (mat_reg[r]),
            .px      (a_reg),
            .py      (b_reg),
            .pz      (c_reg),
            .coord   (coord[r]),
            .clipped (clip[r])
        );
    end

    always_comb
    begin
        mat_next = mat_reg;
        if (advance)
        begin
            if (kind_reg == KIND_IDENTITY)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        mat_next[i][j] = (i == j) ? ONE_Q : '0;
                    end
                end
            end
            else if (kind_reg inside {[KIND_TRANSLATE:KIND_SHEAR]})
            begin
                mat_next = row_new;
            end
        end
    end

    always_comb
    begin
        if (take_cmd)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance && is_point)
        begin
            out_valid_next = 1'b1;
        end
        else if (point.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    mat_reg[i][j] <= (i == j) ? ONE_Q : '0;
                end
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            mat_reg       <= mat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_cmd)
        begin
            kind_reg <= cmd.kind;
            axis_reg <= cmd.axis;
            a_reg    <= cmd.operand_a;
            b_reg    <= cmd.operand_b;
            c_reg    <= cmd.operand_c;
        end
        if (advance && is_point)
        begin
            out_x_reg <= coord[0];
            out_y_reg <= coord[1];
            out_z_reg <= coord[2];
            sat_reg   <= clip[0] | clip[1] | clip[2];
        end
    end

endmodule

// ===== rtl/core/aff3d_checker.sv =====
// Port-level checks of the 3D affine transform composer, bound to its top level.
// Depends on aff3d_pkg for the command codes.
module aff3d_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_ready,
    input aff3d_pkg::kind_t      cmd_kind,
    input logic                  pnt_valid,
    input logic                  pnt_ready,
    input aff3d_pkg::q_t         out_x,
    input aff3d_pkg::q_t         out_y,
    input aff3d_pkg::q_t         out_z,
    input logic                  saturated
);
    import aff3d_pkg::*;

    // A waiting point word keeps its value until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pnt_valid && !pnt_ready |=> pnt_valid && $stable(out_x) && $stable(out_y)
                                    && $stable(out_z) && $stable(saturated))
        else $error("point word changed while stalled");

    // With nothing waiting at the output the command side never stalls.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !pnt_valid |-> cmd_ready)
        else $error("command stalled with empty output");

    // A fresh point word always stems from a point command accepted earlier.
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pnt_valid) |-> $past(cmd_valid && cmd_ready && cmd_kind == KIND_POINT, 2))
        else $error("point word without a point command");

endmodule

bind affine_transform_3d_composer_unit aff3d_checker u_aff3d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_kind  (cmd.kind),
    .pnt_valid (point.valid),
    .pnt_ready (point.ready),
    .out_x     (point.out_x),
    .out_y     (point.out_y),
    .out_z     (point.out_z),
    .saturated (point.saturated)
);

// ===== dv/tb_affine_transform_3d_composer_unit.sv =====
// Testbench for the 3D affine transform composer: random and directed command words, checked
// against a matrix tracker that composes the same transforms in Q16.16.
// Depends on aff3d_pkg, the aff3d_if channel interfaces and the affine_transform_3d_composer_unit.
`timescale 1ns / 100ps

import aff3d_pkg::*;

typedef struct packed {
    kind_t kind;
    axis_t axis;
    q_t    a;
    q_t    b;
    q_t    c;
} cmd_word_t;

typedef struct packed {
    q_t   x;
    q_t   y;
    q_t   z;
    logic sat;
} point_word_t;

class matrix_tracker;
    longint      mat [12];            // row-major, three rows of four
    point_word_t expected_points [$];
    int          commands_seen;
    int          points_seen;
    int          points_checked;
    int          clipped_seen;
    int          errors;

    function new();
        load_identity();
        commands_seen  = 0;
        points_seen    = 0;
        points_checked = 0;
        clipped_seen   = 0;
        errors         = 0;
    endfunction

    function void load_identity();
        for (int i = 0; i < 12; i++)
            mat[i] = (i % 5 == 0) ? longint'(ONE_Q) : 0;
    endfunction

    function longint clip(longint v, int w, inout bit sat);
        longint mx;
        longint mn;
        mx = (longint'(1) <<< (w - 1)) - 1;
        mn = -mx - 1;
        if (v > mx) begin
            sat = 1'b1;
            return mx;
        end
        if (v < mn) begin
            sat = 1'b1;
            return mn;
        end
        return v;
    endfunction

    // Exact three-term product sum, rounded half up to Q16.16, then the translation term and
    // saturation. Each a is split into a high part and a 17-bit low part to keep 64 bits enough.
    function longint round_sum(longint a0, longint a1, longint a2,
                               longint b0, longint b1, longint b2,
                               longint addend, int w, inout bit sat);
        longint hi;
        longint lo;
        longint cap;
        cap = longint'(1) <<< 52;
        hi = (a0 >>> 17) * b0 + (a1 >>> 17) * b1 + (a2 >>> 17) * b2;
        lo = 32768 + (a0 & 64'sh1FFFF) * b0 + (a1 & 64'sh1FFFF) * b1
                   + (a2 & 64'sh1FFFF) * b2;
        if (hi > cap)
            return clip(cap, w, sat);
        if (hi < -cap)
            return clip(-cap, w, sat);
        return clip(2 * hi + (lo >>> 16) + addend, w, sat);
    endfunction

    function void note_command(cmd_word_t w);
        longint      e [12];
        longint      nxt [12];
        longint      a;
        longint      b;
        longint      c;
        bit          compose;
        bit          dropped;
        bit          sat;
        point_word_t p;
        a = longint'(w.a);
        b = longint'(w.b);
        c = longint'(w.c);
        commands_seen++;
        for (int i = 0; i < 12; i++)
            e[i] = (i % 5 == 0) ? longint'(ONE_Q) : 0;
        compose = 1'b1;
        case (w.kind)
            KIND_IDENTITY:
            begin
                load_identity();
                compose = 1'b0;
            end
            KIND_TRANSLATE:
            begin
                e[3] = a; e[7] = b; e[11] = c;
            end
            KIND_SCALE:
            begin
                e[0] = a; e[5] = b; e[10] = c;
            end
            KIND_ROTATE:
            case (w.axis)
                AXIS_X:  begin e[5] = a; e[6] = -b; e[9] = b; e[10] = a; end
                AXIS_Y:  begin e[0] = a; e[2] = b; e[8] = -b; e[10] = a; end
                AXIS_Z:  begin e[0] = a; e[1] = -b; e[4] = b; e[5] = a; end
                default: compose = 1'b0;
            endcase
            // For reflect the axis code picks the negated coordinate: x code -> z, y -> x, z -> y.
            KIND_REFLECT:
            case (w.axis)
                AXIS_X:  e[10] = -longint'(ONE_Q);
                AXIS_Y:  e[0] = -longint'(ONE_Q);
                AXIS_Z:  e[5] = -longint'(ONE_Q);
                default: compose = 1'b0;
            endcase
            KIND_SHEAR:
            case (w.axis)
                AXIS_X:  begin e[1] = a; e[2] = b; end
                AXIS_Y:  begin e[4] = a; e[6] = b; end
                AXIS_Z:  begin e[8] = a; e[9] = b; end
                default: compose = 1'b0;
            endcase
            KIND_POINT:
            begin
                sat = 1'b0;
                p.x = q_t'(round_sum(mat[0], mat[1], mat[2], a, b, c, mat[3], Q_WIDTH, sat));
                p.y = q_t'(round_sum(mat[4], mat[5], mat[6], a, b, c, mat[7], Q_WIDTH, sat));
                p.z = q_t'(round_sum(mat[8], mat[9], mat[10], a, b, c, mat[11], Q_WIDTH, sat));
                p.sat = sat;
                expected_points.push_back(p);
                points_seen++;
                compose = 1'b0;
            end
            default: compose = 1'b0;
        endcase
        if (compose) begin
            // Entries that clip do so silently.
            dropped = 1'b0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 4; j++)
                    nxt[i*4+j] = round_sum(mat[j], mat[4+j], mat[8+j],
                                           e[i*4], e[i*4+1], e[i*4+2],
                                           (j == 3) ? e[i*4+3] : 0, COEFF_WIDTH, dropped);
            mat = nxt;
        end
    endfunction

    function void check_field(string name, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_point(point_word_t got);
        point_word_t want;
        if (expected_points.size() == 0) begin
            errors++;
            $display("%0t: point word with nothing expected, actual %0d %0d %0d sat %0d",
                     $time, got.x, got.y, got.z, got.sat);
            return;
        end
        want = expected_points.pop_front();
        points_checked++;
        if (got.sat)
            clipped_seen++;
        check_field("out_x", longint'(want.x), longint'(got.x));
        check_field("out_y", longint'(want.y), longint'(got.y));
        check_field("out_z", longint'(want.z), longint'(got.z));
        check_field("saturated", longint'(want.sat), longint'(got.sat));
    endfunction
endclass

module tb_affine_transform_3d_composer_unit;

    localparam int     CLK_HALF     = 4;
    localparam int     RANDOM_ITEMS = 1250;
    localparam longint CYCLE_LIMIT  = 200000;

    localparam kind_t KIND_UNUSED = 3'd7;
    localparam q_t    Q_ONE       = 32'sh0001_0000;
    localparam q_t    Q_HALF      = 32'sh0000_8000;
    localparam q_t    Q_MAX       = 32'sh7FFF_FFFF;
    localparam q_t    Q_MIN       = {1'b1, 31'b0};

    logic   clk = 1'b0;
    logic   rst_n;
    int     send_idle_pct;
    int     recv_stall_pct;
    longint cycles;

    aff3d_cmd_if cmd_ch ();
    aff3d_pnt_if pnt_ch ();

    matrix_tracker tracker = new();

    affine_transform_3d_composer_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .point (pnt_ch)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out with %0d points still expected.",
                     tracker.expected_points.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic cmd_word_t make_cmd(kind_t k, axis_t ax, q_t a, q_t b, q_t c);
        cmd_word_t w;
        w.kind = k;
        w.axis = ax;
        w.a    = a;
        w.b    = b;
        w.c    = c;
        return w;
    endfunction

    function automatic q_t spread(int span);
        return q_t'(int'($urandom_range(2 * span, 0)) - span);
    endfunction

    // Scale factor of magnitude 0.5 to 2.0 with a random sign.
    function automatic q_t near_one();
        q_t v;
        v = q_t'($urandom_range(131072, 32768));
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic cmd_word_t random_command();
        cmd_word_t w;
        int        pick;
        bit        raw;
        real       angle;
        pick   = $urandom_range(99);
        raw    = ($urandom_range(9) == 0);
        w.axis = ($urandom_range(19) == 0) ? AXIS_NONE : axis_t'($urandom_range(2));
        w.a    = $urandom;
        w.b    = $urandom;
        w.c    = $urandom;
        if (pick < 6) begin
            w.kind = KIND_IDENTITY;
        end else if (pick < 17) begin
            w.kind = KIND_TRANSLATE;
            if (!raw) begin
                w.a = spread(16 << 16);
                w.b = spread(16 << 16);
                w.c = spread(16 << 16);
            end
        end else if (pick < 27) begin
            w.kind = KIND_SCALE;
            if (!raw) begin
                w.a = near_one();
                w.b = near_one();
                w.c = near_one();
            end
        end else if (pick < 42) begin
            w.kind = KIND_ROTATE;
            if (!raw) begin
                angle = $urandom_range(3599) * 3.14159265358979 / 1800.0;
                w.a   = q_t'($rtoi($cos(angle) * 65536.0));
                w.b   = q_t'($rtoi($sin(angle) * 65536.0));
            end
        end else if (pick < 50) begin
            w.kind = KIND_REFLECT;
        end else if (pick < 58) begin
            w.kind = KIND_SHEAR;
            if (!raw) begin
                w.a = spread(1 << 16);
                w.b = spread(1 << 16);
            end
        end else if (pick < 96) begin
            w.kind = KIND_POINT;
            if (!raw) begin
                w.a = spread(256 << 16);
                w.b = spread(256 << 16);
                w.c = spread(256 << 16);
            end
        end else begin
            w.kind = KIND_UNUSED;
        end
        return w;
    endfunction

    // The valid stays high across back-to-back words; it is only lowered inside an idle gap.
    task automatic send_command(input cmd_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.kind      <= w.kind;
        cmd_ch.axis      <= w.axis;
        cmd_ch.operand_a <= w.a;
        cmd_ch.operand_b <= w.b;
        cmd_ch.operand_c <= w.c;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        tracker.note_command(w);
    endtask

    task automatic run_directed();
        send_command(make_cmd(KIND_POINT, AXIS_X, Q_MAX, Q_MIN, 32'sd0));
        send_command(make_cmd(KIND_TRANSLATE, AXIS_X, Q_MAX, Q_MIN, Q_MAX));
        send_command(make_cmd(KIND_POINT, AXIS_X, Q_MAX, Q_MIN, Q_MAX));
        send_command(make_cmd(KIND_IDENTITY, AXIS_X, 32'sd0, 32'sd0, 32'sd0));
        send_command(make_cmd(KIND_SCALE, AXIS_X, 2 * Q_ONE, -Q_ONE, Q_HALF));
        send_command(make_cmd(KIND_POINT, AXIS_X, 3 * Q_ONE, 5 * Q_ONE, Q_MIN));
        send_command(make_cmd(KIND_ROTATE, AXIS_X, 32'sd0, Q_ONE, 32'sd0));
        // The most negative sine makes the negated term one past the 32-bit range.
        send_command(make_cmd(KIND_ROTATE, AXIS_Y, 32'sd0, Q_MIN, 32'sd0));
        send_command(make_cmd(KIND_ROTATE, AXIS_Z, Q_HALF, 3 * Q_HALF / 2, 32'sd0));
        send_command(make_cmd(KIND_ROTATE, AXIS_NONE, Q_MAX, Q_MAX, Q_MAX));
        send_command(make_cmd(KIND_POINT, AXIS_X, Q_ONE, 2 * Q_ONE, 3 * Q_ONE));
        send_command(make_cmd(KIND_REFLECT, AXIS_X, 32'sd0, 32'sd0, 32'sd0));
        send_command(make_cmd(KIND_REFLECT, AXIS_Y, 32'sd0, 32'sd0, 32'sd0));
        send_command(make_cmd(KIND_REFLECT, AXIS_Z, 32'sd0, 32'sd0, 32'sd0));
        send_command(make_cmd(KIND_REFLECT, AXIS_NONE, 32'sd0, 32'sd0, 32'sd0));
        send_command(make_cmd(KIND_POINT, AXIS_X, -Q_ONE, 7 * Q_ONE, Q_HALF));
        send_command(make_cmd(KIND_SHEAR, AXIS_X, Q_HALF, -Q_HALF / 2, 32'sd0));
        send_command(make_cmd(KIND_SHEAR, AXIS_Y, Q_ONE, Q_HALF, 32'sd0));
        send_command(make_cmd(KIND_SHEAR, AXIS_Z, -Q_ONE, Q_ONE, 32'sd0));
        send_command(make_cmd(KIND_SHEAR, AXIS_NONE, Q_MAX, Q_MIN, 32'sd0));
        send_command(make_cmd(KIND_UNUSED, AXIS_NONE, Q_MIN, Q_MAX, Q_MIN));
        send_command(make_cmd(KIND_POINT, AXIS_X, 9 * Q_ONE, -4 * Q_ONE, 2 * Q_ONE));
        send_command(make_cmd(KIND_SCALE, AXIS_X, Q_MAX, Q_MIN, Q_MAX));
        send_command(make_cmd(KIND_POINT, AXIS_X, Q_MAX, Q_MAX, Q_MIN));
        send_command(make_cmd(KIND_IDENTITY, AXIS_NONE, Q_MAX, Q_MIN, Q_MAX));
        send_command(make_cmd(KIND_POINT, AXIS_X, Q_MIN, Q_MAX, Q_MIN));
    endtask

    // Point channel: check each word taken, then pick the ready level for the next cycle.
    initial
    begin
        point_word_t got;
        pnt_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (pnt_ch.valid && pnt_ch.ready) begin
                got.x   = pnt_ch.out_x;
                got.y   = pnt_ch.out_y;
                got.z   = pnt_ch.out_z;
                got.sat = pnt_ch.saturated;
                tracker.check_point(got);
            end
            pnt_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int idle_mix [4];
        int stall_mix [4];
        idle_mix  = '{0, 45, 0, 26};
        stall_mix = '{0, 0, 45, 26};
        cycles           = 0;
        rst_n            = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.kind      = KIND_IDENTITY;
        cmd_ch.axis      = AXIS_X;
        cmd_ch.operand_a = '0;
        cmd_ch.operand_b = '0;
        cmd_ch.operand_c = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_mix[phase];
            recv_stall_pct = stall_mix[phase];
            repeat (RANDOM_ITEMS / 4)
                send_command(random_command());
        end
        cmd_ch.valid <= 1'b0;

        while (tracker.expected_points.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d command words, %0d of them points, under four idle and stall mixes.",
                 tracker.commands_seen, tracker.points_seen);
        $display("Checked %0d point words, %0d of them clipped; %0d mismatches.",
                 tracker.points_checked, tracker.clipped_seen, tracker.errors);
        if (tracker.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
